// ===== hw/rtl/fvc_pkg.sv =====
// Shared types and constants for the flow vector colour coder.
`default_nettype none
package fvc_pkg;

    typedef struct packed {
        logic signed [15:0] flow_u;
        logic signed [15:0] flow_v;
    } t_flow_in;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_colour_out;

    localparam int ANGLE_BITS    = 24;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_W      = 36;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 17;
    localparam int COLOUR_STAGES = 3;
    localparam logic [15:0] MAX_RESET = 16'd640;

    // atan(2^-i) as a fraction of a turn, Q0.24
    localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
        24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304,
        24'd652, 24'd326, 24'd163, 24'd81, 24'd41, 24'd20,
        24'd10, 24'd5, 24'd3, 24'd1, 24'd1, 24'd0
    };

endpackage
`default_nettype wire

// ===== hw/rtl/fvc_cordic.sv =====
// Pipelined vectoring CORDIC: one micro-rotation per stage, angle in turns.
`default_nettype none
module fvc_cordic
    import fvc_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [CORDIC_W-1:0]   i_x,
    input  wire logic signed [CORDIC_W-1:0]   i_y,
    input  wire logic [ANGLE_BITS-1:0]        i_ang,
    output logic [ANGLE_BITS-1:0]             o_ang
);

    logic signed [CORDIC_W-1:0] r_x [0:STAGES-2];
    logic signed [CORDIC_W-1:0] r_y [0:STAGES-2];
    logic [ANGLE_BITS-1:0]      r_a [0:STAGES-1];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [CORDIC_W-1:0] p_x, p_y, n_x, n_y;
        logic [ANGLE_BITS-1:0]      p_a, n_a;

        if (g == 0) begin : g_first
            assign p_x = i_x;
            assign p_y = i_y;
            assign p_a = i_ang;
        end else begin : g_rest
            assign p_x = r_x[g-1];
            assign p_y = r_y[g-1];
            assign p_a = r_a[g-1];
        end

        always_comb begin
            if (!p_y[CORDIC_W-1]) begin
                n_x = p_x + (p_y >>> g);
                n_y = p_y - (p_x >>> g);
                n_a = p_a + ATAN_TURNS[g];
            end else begin
                n_x = p_x - (p_y >>> g);
                n_y = p_y + (p_x >>> g);
                n_a = p_a - ATAN_TURNS[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[g] <= n_a;
            end
        end

        if (g < STAGES - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g] <= n_x;
                    r_y[g] <= n_y;
                end
            end
        end
    end

    assign o_ang = r_a[STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/fvc_sqrt.sv =====
// Pipelined digit-by-digit square root of sq * 2^32, one root bit per stage.
`default_nettype none
module fvc_sqrt
    import fvc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_sq,
    output logic [31:0]      o_root
);

    logic [35:0] r_rem  [0:SQRT_STAGES-2];
    logic [63:0] r_n    [0:SQRT_STAGES-2];
    logic [31:0] r_root [0:SQRT_STAGES-1];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic [35:0] p_rem, rt, trial, n_rem;
        logic [63:0] p_n;
        logic [31:0] p_root, n_root;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_n    = {i_sq, 32'd0};
            assign p_root = '0;
        end else begin : g_rest
            assign p_rem  = r_rem[g-1];
            assign p_n    = r_n[g-1];
            assign p_root = r_root[g-1];
        end

        always_comb begin
            rt    = {p_rem[33:0], p_n[63:62]};
            trial = {2'b00, p_root, 2'b01};
            if (rt >= trial) begin
                n_rem  = rt - trial;
                n_root = {p_root[30:0], 1'b1};
            end else begin
                n_rem  = rt;
                n_root = {p_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[g] <= n_root;
            end
        end

        if (g < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_n[g]   <= {p_n[61:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/fvc_div.sv =====
// Pipelined saturation divider: min(65536, mag * gain / max), one quotient bit per stage.
`default_nettype none
module fvc_div
    import fvc_pkg::*;
#(
    parameter int SAT_GAIN = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_mag,
    input  wire logic [15:0] i_max,
    output logic [16:0]      o_sat
);

    localparam int DW = 32 + $clog2(SAT_GAIN + 1);

    logic [DW-1:0] r_rem [0:DIV_STAGES-2];
    logic [15:0]   r_q   [1:DIV_STAGES-1];
    logic          r_sat [0:DIV_STAGES-1];
    logic [DW-1:0] dividend;

    assign dividend = DW'(i_mag) * DW'(SAT_GAIN);

    // first stage: anything at or above max << 16 clamps to full saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= dividend;
            r_sat[0] <= (dividend >= (DW'(i_max) << 16));
        end
    end

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_stage
        logic [DW-1:0] dv, n_rem;
        logic [15:0]   p_q, n_q;
        logic          take;

        if (g == 1) begin : g_first
            assign p_q = '0;
        end else begin : g_rest
            assign p_q = r_q[g-1];
        end

        always_comb begin
            dv    = DW'(i_max) << (DIV_STAGES - 1 - g);
            take  = (r_rem[g-1] >= dv);
            n_rem = take ? (r_rem[g-1] - dv) : r_rem[g-1];
            n_q   = {p_q[14:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]   <= n_q;
                r_sat[g] <= r_sat[g-1];
            end
        end

        if (g < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                end
            end
        end
    end

    assign o_sat = r_sat[DIV_STAGES-1] ? 17'h10000 : {1'b0, r_q[DIV_STAGES-1]};

endmodule
`default_nettype wire

// ===== hw/rtl/fvc_colour.sv =====
// Hue sextant and chroma to blue, green, red; three register stages.
`default_nettype none
module fvc_colour
    import fvc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [16:0]           i_sat,
    input  wire logic [ANGLE_BITS-1:0] i_ang,
    output t_colour_out                o_colour
);

    logic [26:0] h6;
    logic [24:0] n1_f;
    logic [2:0]  r1_sext, r2_sext;
    logic [24:0] r1_f;
    logic [23:0] r1_cc;
    logic [48:0] r2_prod;
    logic [7:0]  r2_c, x;

    always_comb begin
        h6 = 27'(i_ang) * 27'd6;
        if (h6[24]) begin
            n1_f = 25'h1000000 - {1'b0, h6[23:0]};
        end else begin
            n1_f = {1'b0, h6[23:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sext <= h6[26:24];
            r1_f    <= n1_f;
            r1_cc   <= 24'({7'd0, i_sat} * 24'd255);
            r2_prod <= 49'(r1_cc) * 49'(r1_f);
            r2_c    <= r1_cc[23:16];
            r2_sext <= r1_sext;
        end
    end

    assign x = r2_prod[47:40];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r2_sext)
                3'd0: o_colour <= '{blue: 8'd0, green: x,    red: r2_c};
                3'd1: o_colour <= '{blue: 8'd0, green: r2_c, red: x};
                3'd2: o_colour <= '{blue: x,    green: r2_c, red: 8'd0};
                3'd3: o_colour <= '{blue: r2_c, green: x,    red: 8'd0};
                3'd4: o_colour <= '{blue: r2_c, green: 8'd0, red: x};
                default: o_colour <= '{blue: x, green: 8'd0, red: r2_c};
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/flow_vector_to_color.sv =====
// Optical-flow vector to HSV colour code, fully pipelined.
// Input channel: i_in_valid / o_in_stall carry one flow item (u, v, signed
// Q10.6) in i_in_data; an item is taken on a clock edge with valid high and
// stall low. Output channel: o_out_valid / i_out_stall carry one blue, green,
// red item in o_out_data, held steady while stalled.
// Config: i_cfg_we writes i_cfg_wdata into the maximum magnitude (Q10.6, 0 treated
// as 1; saturation is full at max / SAT_GAIN); write only while the pipe is empty.
// Depth: 2 + 32 + 17 + 3 = 54 register stages from i_in_data to o_out_data.
// Throughput: one item per cycle while the output is not stalled; the 32-stage
// square root, the 17-stage divider and the CORDIC all advance one stage per cycle.
// The CORDIC angle runs beside the root and waits in a delay line.
// A stall at the output freezes every stage at once, so o_in_stall rises
// only while a finished item sits unread at the output; nothing is lost or
// repeated. Synchronous reset empties the pipe and sets the maximum to 640.
`default_nettype none
module flow_vector_to_color
    import fvc_pkg::*;
#(
    parameter int SAT_GAIN      = 8,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_flow_in    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_colour_out      o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int LAT = 2 + SQRT_STAGES + DIV_STAGES + COLOUR_STAGES;
    localparam int AD  = SQRT_STAGES + DIV_STAGES - CORDIC_STAGES;

    logic                       en;
    logic [LAT-1:0]             r_vld;
    logic [15:0]                r_max;
    logic [15:0]                max_eff;
    t_flow_in                   r_in;
    logic [31:0]                r_sq;
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic [ANGLE_BITS-1:0]      r_ca;
    logic [ANGLE_BITS-1:0]      cordic_ang;
    logic [ANGLE_BITS-1:0]      r_adly [0:AD-1];
    logic [31:0]                mag;
    logic [16:0]                sat;
    logic signed [CORDIC_W-1:0] ux, vy;
    logic signed [31:0]         uu, vv;

    // whole pipe moves unless a finished item waits at the output
    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];
    assign max_eff     = (r_max == 16'd0) ? 16'd1 : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_max <= MAX_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        uu = 32'(r_in.flow_u) * 32'(r_in.flow_u);
        vv = 32'(r_in.flow_v) * 32'(r_in.flow_v);
        ux = CORDIC_W'(r_in.flow_u) <<< 16;
        vy = CORDIC_W'(r_in.flow_v) <<< 16;
    end

    // input register, then squares and the left half-plane fold
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in_data;
            r_sq <= unsigned'(uu) + unsigned'(vv);
            if (ux < 0) begin
                r_cx <= -ux;
                r_cy <= -vy;
                r_ca <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
            end else begin
                r_cx <= ux;
                r_cy <= vy;
                r_ca <= '0;
            end
        end
    end

    fvc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_cx),
        .i_y   (r_cy),
        .i_ang (r_ca),
        .o_ang (cordic_ang)
    );

    // angle waits for the root and the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_adly[0] <= cordic_ang;
            for (int k = 1; k < AD; k++) begin
                r_adly[k] <= r_adly[k-1];
            end
        end
    end

    fvc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_sq),
        .o_root (mag)
    );

    fvc_div #(.SAT_GAIN(SAT_GAIN)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (mag),
        .i_max (max_eff),
        .o_sat (sat)
    );

    fvc_colour u_colour (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_sat    (sat),
        .i_ang    (r_adly[AD-1]),
        .o_colour (o_out_data)
    );

endmodule
`default_nettype wire
